@@ rtl/yuv_procamp_adjust_defines.svh @@
// yuv_procamp_adjust_defines.svh: assertion macros for the procamp checker.
// Needs a clock named clock and a reset named reset in the including scope.
`ifndef YUV_PROCAMP_ADJUST_DEFINES_SVH
`define YUV_PROCAMP_ADJUST_DEFINES_SVH

// Checked outside reset.
`define YPA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define YPA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/ypa_pkg.sv @@
// ypa_pkg: beat types, register indexes and the output clamp of the procamp.
// No dependencies.
`default_nettype none

package ypa_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 10;

   typedef enum logic [CsrIndexWidth-1:0] {
      REG_CONTRAST   = 3'd0,
      REG_BRIGHTNESS = 3'd1,
      REG_HUE_SINE   = 3'd2,
      REG_HUE_COSINE = 3'd3,
      REG_SATURATION = 3'd4
   } ypa_reg_type;

   typedef struct packed {
      logic [7:0] luma_in;
      logic [7:0] cb_in;
      logic [7:0] cr_in;
      logic       chroma_present;
   } ypa_req_type;

   typedef struct packed {
      logic [7:0] luma_out;
      logic [7:0] cb_out;
      logic [7:0] cr_out;
      logic       chroma_valid;
   } ypa_rsp_type;

   localparam logic [8:0]        ContrastReset   = 9'd128;
   localparam logic signed [9:0] BrightnessReset = 10'sd0;
   localparam logic signed [8:0] HueSineReset    = 9'sd0;
   localparam logic signed [8:0] HueCosineReset  = 9'sd128;
   localparam logic [7:0]        SaturationReset = 8'd64;

   // Saturate a signed value to 0..255.
   function automatic logic [7:0] ypa_clamp8(input logic signed [20:0] x);
      logic [7:0] r;
      if (x < 21'sd0) begin
         r = 8'd0;
      end else if (x > 21'sd255) begin
         r = 8'd255;
      end else begin
         r = x[7:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/yuv_procamp_adjust.sv @@
// yuv_procamp_adjust: four-stage brightness/contrast/hue/saturation pipeline.
// Depends on ypa_pkg.
//
//   channel   ports                       beat
//   --------  --------------------------  -----------------------------------
//   input     req_valid/req_ready/req_data luma, Cb, Cr, chroma flag
//   output    rsp_valid/rsp_ready/rsp_data adjusted luma, Cb, Cr, chroma flag
//   config    csr_write_en/index/data      one register write per cycle
//
// One beat per clock sustained while rsp_ready holds; a beat passes through
// products, shift/sum, saturation products and clamp into the output register.
// Each stage moves when it is empty or the stage after it moves, so bubbles
// collapse and a stalled output still lets upstream stages fill.
// Reset (synchronous) clears the stage valids and loads register defaults.
`default_nettype none

module yuv_procamp_adjust
   import ypa_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire ypa_req_type              req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output ypa_rsp_type                   rsp_data,
   input  wire logic                     csr_write_en,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_write_data
);

   // ---------------- configuration registers ----------------
   logic [8:0]        contrast_ff;
   logic signed [9:0] brightness_ff;
   logic signed [8:0] hue_sine_ff;
   logic signed [8:0] hue_cosine_ff;
   logic [7:0]        saturation_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         contrast_ff   <= ContrastReset;
         brightness_ff <= BrightnessReset;
         hue_sine_ff   <= HueSineReset;
         hue_cosine_ff <= HueCosineReset;
         saturation_ff <= SaturationReset;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_CONTRAST:   contrast_ff   <= csr_write_data[8:0];
            REG_BRIGHTNESS: brightness_ff <= $signed(csr_write_data);
            REG_HUE_SINE:   hue_sine_ff   <= $signed(csr_write_data[8:0]);
            REG_HUE_COSINE: hue_cosine_ff <= $signed(csr_write_data[8:0]);
            REG_SATURATION: saturation_ff <= csr_write_data[7:0];
            default: ;   // unknown index: write dropped
         endcase
      end
   end

   // ---------------- stage control ----------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic adv1, adv2, adv3, adv4;

   assign adv4      = !rsp_valid_ff || rsp_ready;
   assign adv3      = !s3_valid_ff || adv4;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_ready = adv1;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff  <= req_valid;
         if (adv2) s2_valid_ff  <= s1_valid_ff;
         if (adv3) s3_valid_ff  <= s2_valid_ff;
         if (adv4) rsp_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------- stage 1: gain and rotation products ----------------
   // x - 128 on an 8-bit sample is just the MSB flipped, read as signed.
   logic signed [7:0]  du, dv;
   logic [16:0]        luma_prod_in, luma_prod_ff;
   logic signed [16:0] cb_cos_in, cr_sin_in, cr_cos_in, cb_sin_in;
   logic signed [16:0] cb_cos_ff, cr_sin_ff, cr_cos_ff, cb_sin_ff;
   logic               chroma_s1_ff;

   assign du           = $signed({~req_data.cb_in[7], req_data.cb_in[6:0]});
   assign dv           = $signed({~req_data.cr_in[7], req_data.cr_in[6:0]});
   assign luma_prod_in = 17'(req_data.luma_in) * 17'(contrast_ff);
   assign cb_cos_in    = 17'(du) * 17'(hue_cosine_ff);
   assign cr_sin_in    = 17'(dv) * 17'(hue_sine_ff);
   assign cr_cos_in    = 17'(dv) * 17'(hue_cosine_ff);
   assign cb_sin_in    = 17'(du) * 17'(hue_sine_ff);

   always_ff @(posedge clock) begin
      if (adv1) begin
         luma_prod_ff <= luma_prod_in;
         cb_cos_ff    <= cb_cos_in;
         cr_sin_ff    <= cr_sin_in;
         cr_cos_ff    <= cr_cos_in;
         cb_sin_ff    <= cb_sin_in;
         chroma_s1_ff <= req_data.chroma_present;
      end
   end

   // ---------------- stage 2: floor shifts, offset and rotation sums ------
   logic signed [11:0] luma_sum_in, luma_sum_ff;
   logic signed [11:0] ub_in, vr_in, ub_ff, vr_ff;
   logic signed [16:0] cb_cos_sh, cr_sin_sh, cr_cos_sh, cb_sin_sh;
   logic               chroma_s2_ff;

   assign cb_cos_sh   = cb_cos_ff >>> 7;
   assign cr_sin_sh   = cr_sin_ff >>> 7;
   assign cr_cos_sh   = cr_cos_ff >>> 7;
   assign cb_sin_sh   = cb_sin_ff >>> 7;
   assign luma_sum_in = $signed({2'b00, luma_prod_ff[16:7]}) + 12'(brightness_ff);
   assign ub_in       = 12'(cb_cos_sh) + 12'(cr_sin_sh);
   assign vr_in       = 12'(cr_cos_sh) - 12'(cb_sin_sh);

   always_ff @(posedge clock) begin
      if (adv2) begin
         luma_sum_ff  <= luma_sum_in;
         ub_ff        <= ub_in;
         vr_ff        <= vr_in;
         chroma_s2_ff <= chroma_s1_ff;
      end
   end

   // ---------------- stage 3: saturation products, luma clamp ------------
   logic signed [8:0]  sat_s;
   logic signed [20:0] ub_sat_in, vr_sat_in, ub_sat_ff, vr_sat_ff;
   logic [7:0]         luma_s3_ff;
   logic               chroma_s3_ff;

   assign sat_s     = $signed({1'b0, saturation_ff});
   assign ub_sat_in = 21'(ub_ff) * 21'(sat_s);
   assign vr_sat_in = 21'(vr_ff) * 21'(sat_s);

   always_ff @(posedge clock) begin
      if (adv3) begin
         ub_sat_ff    <= ub_sat_in;
         vr_sat_ff    <= vr_sat_in;
         luma_s3_ff   <= ypa_clamp8(21'(luma_sum_ff));
         chroma_s3_ff <= chroma_s2_ff;
      end
   end

   // ---------------- stage 4: re-center, clamp, output register ----------
   logic signed [20:0] cb_center, cr_center;
   ypa_rsp_type        rsp_in, rsp_ff;

   assign cb_center = (ub_sat_ff >>> 6) + 21'sd128;
   assign cr_center = (vr_sat_ff >>> 6) + 21'sd128;

   always_comb begin
      rsp_in.luma_out     = luma_s3_ff;
      rsp_in.chroma_valid = chroma_s3_ff;
      // no chroma pair: chroma fields read zero
      rsp_in.cb_out       = chroma_s3_ff ? ypa_clamp8(cb_center) : 8'd0;
      rsp_in.cr_out       = chroma_s3_ff ? ypa_clamp8(cr_center) : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/ypa_checker.sv @@
// ypa_checker: port-level assertions for yuv_procamp_adjust, bound to it.
// Depends on ypa_pkg and yuv_procamp_adjust_defines.svh.
`default_nettype none
`include "yuv_procamp_adjust_defines.svh"

module ypa_checker
   import ypa_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire ypa_rsp_type rsp_data
);

   // a stalled result beat holds
   `YPA_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "rsp beat changed while stalled")

   // items without chroma carry zero chroma
   `YPA_ASSERT(a_no_chroma_zero, rsp_valid && !rsp_data.chroma_valid |-> rsp_data.cb_out == 8'd0 && rsp_data.cr_out == 8'd0, "chroma nonzero without chroma pair")

   // pipeline is empty the cycle after a reset edge
   `YPA_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "rsp_valid high after reset")

endmodule

bind yuv_procamp_adjust ypa_checker u_ypa_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

@@ bench/tb_yuv_procamp_adjust.sv @@
// tb_yuv_procamp_adjust: self-checking bench for the procamp pipeline.
// Needs ypa_pkg and yuv_procamp_adjust from rtl; nothing else.
`timescale 1ns / 100ps

module tb_yuv_procamp_adjust;
   import ypa_pkg::*;

   // Registers 5..7 are unused; writes there must be dropped.
   localparam logic [CsrIndexWidth-1:0] FirstUnusedReg = 3'd5;
   localparam logic [CsrIndexWidth-1:0] LastUnusedReg  = 3'd7;

   localparam int CycleLimit      = 200000;
   localparam int PipeDrainCycles = 8;      // four stages, doubled
   localparam int BeatsPerSetting = 108;    // x 4 settings x 3 idle modes = 1296 beats
   localparam int SettingsPerMode = 4;

   // One row of the directed table: either a register write or a beat.
   // When rsp_known is set the expected beat is typed into the row
   // instead of coming from the predictor.
   typedef struct packed {
      logic                     is_csr;
      logic [CsrIndexWidth-1:0] reg_idx;
      logic [CsrDataWidth-1:0]  reg_val;
      ypa_req_type              beat;
      logic                     rsp_known;
      ypa_rsp_type              rsp;
   } directed_row_type;

   localparam int NumDirected = 29;
   localparam directed_row_type DirectedRows [NumDirected] = '{
      // reset settings: unity gains, no rotation
      '{1'b0, 3'd0, 10'd0, '{8'd0,   8'd128, 8'd128, 1'b1}, 1'b1, '{8'd0,   8'd128, 8'd128, 1'b1}},
      '{1'b0, 3'd0, 10'd0, '{8'd255, 8'd0,   8'd255, 1'b1}, 1'b1, '{8'd255, 8'd0,   8'd255, 1'b1}},
      // no chroma pair: Cb/Cr forced to zero, flag clear
      '{1'b0, 3'd0, 10'd0, '{8'd170, 8'd85,  8'd170, 1'b0}, 1'b1, '{8'd170, 8'd0,   8'd0,   1'b0}},
      '{1'b0, 3'd0, 10'd0, '{8'd85,  8'd170, 8'd85,  1'b1}, 1'b1, '{8'd85,  8'd170, 8'd85,  1'b1}},
      // zero contrast kills luma
      '{1'b1, REG_CONTRAST, 10'd0, '0, 1'b0, '0},
      '{1'b0, 3'd0, 10'd0, '{8'd255, 8'd255, 8'd0,   1'b0}, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
      // top brightness clamps high
      '{1'b1, REG_BRIGHTNESS, 10'd256, '0, 1'b0, '0},
      '{1'b0, 3'd0, 10'd0, '{8'd0,   8'd17,  8'd34,  1'b0}, 1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}},
      // full-width patterns beyond the stated range, then brightness at its low end (-256)
      '{1'b1, REG_CONTRAST,   10'h1FF, '0, 1'b0, '0},
      '{1'b1, REG_BRIGHTNESS, 10'h200, '0, 1'b0, '0},
      '{1'b0, 3'd0, 10'd0, '{8'd255, 8'd3,   8'd250, 1'b0}, 1'b0, '0},
      '{1'b1, REG_BRIGHTNESS, 10'h300, '0, 1'b0, '0},
      '{1'b0, 3'd0, 10'd0, '{8'd128, 8'd64,  8'd192, 1'b1}, 1'b0, '0},
      // quarter-turn hue
      '{1'b1, REG_HUE_SINE,   10'd128, '0, 1'b0, '0},
      '{1'b1, REG_HUE_COSINE, 10'd0,   '0, 1'b0, '0},
      '{1'b0, 3'd0, 10'd0, '{8'd40,  8'd0,   8'd255, 1'b1}, 1'b0, '0},
      '{1'b0, 3'd0, 10'd0, '{8'd200, 8'd255, 8'd0,   1'b1}, 1'b0, '0},
      // most negative sine, largest cosine pattern
      '{1'b1, REG_HUE_SINE,   10'h100, '0, 1'b0, '0},
      '{1'b1, REG_HUE_COSINE, 10'h0FF, '0, 1'b0, '0},
      '{1'b0, 3'd0, 10'd0, '{8'd1,   8'd255, 8'd255, 1'b1}, 1'b0, '0},
      '{1'b0, 3'd0, 10'd0, '{8'd254, 8'd0,   8'd0,   1'b1}, 1'b0, '0},
      // zero saturation: chroma collapses to neutral
      '{1'b1, REG_SATURATION, 10'd0, '0, 1'b0, '0},
      '{1'b0, 3'd0, 10'd0, '{8'd0,   8'd0,   8'd255, 1'b1}, 1'b1, '{8'd0,   8'd128, 8'd128, 1'b1}},
      '{1'b1, REG_SATURATION, 10'h0FF, '0, 1'b0, '0},
      '{1'b0, 3'd0, 10'd0, '{8'd99,  8'd200, 8'd60,  1'b1}, 1'b0, '0},
      '{1'b0, 3'd0, 10'd0, '{8'd160, 8'd128, 8'd0,   1'b1}, 1'b0, '0},
      // unused indexes: nothing may change
      '{1'b1, FirstUnusedReg, 10'h3FF, '0, 1'b0, '0},
      '{1'b1, LastUnusedReg,  10'h000, '0, 1'b0, '0},
      '{1'b0, 3'd0, 10'd0, '{8'd255, 8'd1,   8'd254, 1'b1}, 1'b0, '0}
   };

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_ready;
   ypa_req_type              req_data       = '0;
   logic                     rsp_valid;
   logic                     rsp_ready      = 1'b0;
   ypa_rsp_type              rsp_data;
   logic                     csr_write_en   = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index      = '0;
   logic [CsrDataWidth-1:0]  csr_write_data = '0;

   // Bench copy of the register file.
   logic [8:0]        gain_q;
   logic signed [9:0] offset_q;
   logic signed [8:0] sine_q;
   logic signed [8:0] cosine_q;
   logic [7:0]        sat_q;

   ypa_rsp_type pixels_due [$];   // adjusted pixels still to come, oldest first
   int          mismatch_count = 0;
   int          cycle_count    = 0;
   int          tx_idle_pct    = 26;
   int          rx_idle_pct    = 46;

   yuv_procamp_adjust u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------
   function automatic logic [7:0] saturate_byte(input int x);
      logic [7:0] r;
      if (x < 0) begin
         r = 8'd0;
      end else if (x > 255) begin
         r = 8'd255;
      end else begin
         r = x[7:0];
      end
      return r;
   endfunction

   // >>> on a signed int floors, which is what every shift here needs.
   function automatic ypa_rsp_type procamp_pixel(input ypa_req_type beat);
      ypa_rsp_type r;
      int          luma;
      int          du;
      int          dv;
      int          ub;
      int          vr;
      luma = ((int'(beat.luma_in) * int'(gain_q)) >>> 7) + int'(offset_q);
      r = '0;
      r.luma_out     = saturate_byte(luma);
      r.chroma_valid = beat.chroma_present;
      if (beat.chroma_present) begin
         du = int'(beat.cb_in) - 128;
         dv = int'(beat.cr_in) - 128;
         ub = ((du * int'(cosine_q)) >>> 7) + ((dv * int'(sine_q)) >>> 7);
         vr = ((dv * int'(cosine_q)) >>> 7) - ((du * int'(sine_q)) >>> 7);
         r.cb_out = saturate_byte(((ub * int'(sat_q)) >>> 6) + 128);
         r.cr_out = saturate_byte(((vr * int'(sat_q)) >>> 6) + 128);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // Called at a rising edge. Write lands at the next edge; the model
   // follows right away since the pipe is empty by then. Returns with
   // the enable already low.
   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] val);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         REG_CONTRAST:   gain_q   = val[8:0];
         REG_BRIGHTNESS: offset_q = val[9:0];
         REG_HUE_SINE:   sine_q   = val[8:0];
         REG_HUE_COSINE: cosine_q = val[8:0];
         REG_SATURATION: sat_q    = val[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Called at a rising edge; returns at the edge the beat is taken, with
   // req_valid still high so back-to-back beats need no extra assignment.
   task automatic send_beat(input ypa_req_type beat, input logic known,
                            input ypa_rsp_type rsp);
      int gap;
      gap = 0;
      while ($urandom_range(99) < tx_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pixels_due.push_back(known ? rsp : procamp_pixel(beat));
   endtask

   // Drop valid and hold off until every due pixel is out. Always waits
   // for an edge first, so req_valid never gets two updates in one step.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pixels_due.size() != 0);
   endtask

   // Register value: stated extremes, in range, or any bit pattern.
   function automatic logic [CsrDataWidth-1:0] pick_setting(input int lo, input int hi);
      int v;
      case ($urandom_range(4))
         0: v = lo;
         1: v = hi;
         2: v = int'($urandom_range(1023));
         default: v = lo + int'($urandom_range(hi - lo));
      endcase
      return CsrDataWidth'(v);
   endfunction

   // Samples lean toward black, white and neutral chroma.
   function automatic logic [7:0] pick_sample();
      logic [7:0] s;
      case ($urandom_range(7))
         0: s = 8'd0;
         1: s = 8'd255;
         2: s = 8'd128;
         default: s = 8'($urandom);
      endcase
      return s;
   endfunction

   task automatic shuffle_settings();
      write_reg(REG_CONTRAST,   pick_setting(0, 256));
      write_reg(REG_BRIGHTNESS, pick_setting(-256, 256));
      write_reg(REG_HUE_SINE,   pick_setting(-128, 128));
      write_reg(REG_HUE_COSINE, pick_setting(-128, 128));
      write_reg(REG_SATURATION, pick_setting(0, 128));
      if ($urandom_range(3) == 0) begin
         write_reg(CsrIndexWidth'($urandom_range(FirstUnusedReg, LastUnusedReg)),
                   CsrDataWidth'($urandom));
      end
   endtask

   // ---------------------------------------------------------------
   // Receiver stalls and result check
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      ypa_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixels_due.size() == 0) begin
            report_mismatch($sformatf("beat with none due (luma %0d cb %0d cr %0d)",
                            rsp_data.luma_out, rsp_data.cb_out, rsp_data.cr_out));
         end else begin
            want = pixels_due.pop_front();
            if (rsp_data.luma_out !== want.luma_out)
               report_mismatch($sformatf("luma_out %0d, want %0d",
                               rsp_data.luma_out, want.luma_out));
            if (rsp_data.cb_out !== want.cb_out)
               report_mismatch($sformatf("cb_out %0d, want %0d",
                               rsp_data.cb_out, want.cb_out));
            if (rsp_data.cr_out !== want.cr_out)
               report_mismatch($sformatf("cr_out %0d, want %0d",
                               rsp_data.cr_out, want.cr_out));
            if (rsp_data.chroma_valid !== want.chroma_valid)
               report_mismatch($sformatf("chroma_valid %0b, want %0b",
                               rsp_data.chroma_valid, want.chroma_valid));
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("tb_yuv_procamp_adjust NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   initial begin
      ypa_req_type beat;
      gain_q   = ContrastReset;
      offset_q = BrightnessReset;
      sine_q   = HueSineReset;
      cosine_q = HueCosineReset;
      sat_q    = SaturationReset;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table; register rows wait for an empty pipe first.
      for (int i = 0; i < NumDirected; i++) begin
         if (DirectedRows[i].is_csr) begin
            wait_drained();
            write_reg(DirectedRows[i].reg_idx, DirectedRows[i].reg_val);
         end else begin
            send_beat(DirectedRows[i].beat, DirectedRows[i].rsp_known,
                      DirectedRows[i].rsp);
         end
      end

      // Random part: sender-light/receiver-heavy idling, then swapped,
      // then full rate. Each mode runs several register settings.
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin tx_idle_pct = 26; rx_idle_pct = 46; end
            1: begin tx_idle_pct = 46; rx_idle_pct = 26; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         for (int set = 0; set < SettingsPerMode; set++) begin
            wait_drained();
            shuffle_settings();
            for (int n = 0; n < BeatsPerSetting; n++) begin
               // mid-setting hold-off until the pipe has emptied
               if (n == BeatsPerSetting / 2) wait_drained();
               beat.luma_in        = pick_sample();
               beat.cb_in          = pick_sample();
               beat.cr_in          = pick_sample();
               beat.chroma_present = 1'($urandom_range(1));
               send_beat(beat, 1'b0, '0);
            end
         end
      end

      wait_drained();
      repeat (PipeDrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_yuv_procamp_adjust OK");
      end else begin
         $display("tb_yuv_procamp_adjust NOT OK");
      end
      $finish;
   end

endmodule

@@ yuv_procamp_adjust.f @@
+incdir+rtl
rtl/ypa_pkg.sv
rtl/yuv_procamp_adjust.sv
rtl/ypa_checker.sv
bench/tb_yuv_procamp_adjust.sv
